### sv/blit_rectangle_clipper_top_macros.svh
// Assertion macros for the blit rectangle clipper
`ifndef BLIT_RECTANGLE_CLIPPER_TOP_MACROS_SVH
`define BLIT_RECTANGLE_CLIPPER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// a implies b in the same cycle
`define BRC_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("brc assertion failed");

// a implies b in the next cycle
`define BRC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("brc assertion failed");

`else

`define BRC_ASSERT_IMPL(label, clk, rst_n, a, b)
`define BRC_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

### sv/brc_pkg.sv
package brc_pkg;

    // internal coordinate; 18 bits signed holds every intermediate value
    typedef logic signed [17:0] coord_t;

    typedef struct packed {
        coord_t x1;
        coord_t x2;
        coord_t y1;
        coord_t y2;
        coord_t sx;
        coord_t sy;
        coord_t w;
        coord_t h;
        logic   ok;
        logic   again;
    } clip_state_t;

    typedef struct packed {
        coord_t cl;
        coord_t ct;
        coord_t cr;
        coord_t cb;
    } window_t;

    typedef struct packed {
        clip_state_t st;
        window_t     win;
        coord_t      bw;
        coord_t      bh;
    } stage_t;

    // configuration register indexes
    localparam logic [2:0] CFG_WIN_LEFT       = 3'd0;
    localparam logic [2:0] CFG_WIN_TOP        = 3'd1;
    localparam logic [2:0] CFG_WIN_RIGHT      = 3'd2;
    localparam logic [2:0] CFG_WIN_BOTTOM     = 3'd3;
    localparam logic [2:0] CFG_ALT_WIN_LEFT   = 3'd4;
    localparam logic [2:0] CFG_ALT_WIN_TOP    = 3'd5;
    localparam logic [2:0] CFG_ALT_WIN_RIGHT  = 3'd6;
    localparam logic [2:0] CFG_ALT_WIN_BOTTOM = 3'd7;

    // window reset values
    localparam logic [11:0] WIN_LEFT_RST   = 12'd0;
    localparam logic [11:0] WIN_TOP_RST    = 12'd0;
    localparam logic [11:0] WIN_RIGHT_RST  = 12'd1023;
    localparam logic [11:0] WIN_BOTTOM_RST = 12'd767;

endpackage

### sv/brc_clip_pass.sv
// One clipping pass: reject, trim to window, fix negative source offset,
// clamp to bitmap. Passes the state through when no pass is due.
module brc_clip_pass
    import brc_pkg::*;
(
    input  clip_state_t st_in,
    input  window_t     win,
    input  coord_t      bw,
    input  coord_t      bh,
    output clip_state_t st_out
);

    clip_state_t s;

    always_comb
    begin
        s = st_in;
        if (st_in.again && st_in.ok)
        begin
            s.again = 1'b0;
            if (s.x1 > win.cr || s.x2 < win.cl || s.y1 > win.cb || s.y2 < win.ct)
            begin
                s.ok = 1'b0;
            end
            else
            begin
                if (s.x1 < win.cl)
                begin
                    s.sx = s.sx + win.cl - s.x1;
                    s.x1 = win.cl;
                end
                if (s.y1 < win.ct)
                begin
                    s.sy = s.sy + win.ct - s.y1;
                    s.y1 = win.ct;
                end
                if (s.x2 > win.cr)
                begin
                    s.x2 = win.cr;
                end
                if (s.y2 > win.cb)
                begin
                    s.y2 = win.cb;
                end
                // negative source offset pushes the destination right/down
                if (s.sx < 0)
                begin
                    s.x1    = s.x1 - s.sx;
                    s.sx    = '0;
                    s.again = 1'b1;
                end
                if (s.sy < 0)
                begin
                    s.y1    = s.y1 - s.sy;
                    s.sy    = '0;
                    s.again = 1'b1;
                end
                s.w = s.x2 - s.x1 + 18'sd1;
                s.h = s.y2 - s.y1 + 18'sd1;
                if (s.sx + s.w > bw)
                begin
                    s.w  = bw - s.sx;
                    s.x2 = s.x1 + s.w - 18'sd1;
                end
                if (s.sy + s.h > bh)
                begin
                    s.h  = bh - s.sy;
                    s.y2 = s.y1 + s.h - 18'sd1;
                end
                if (s.w < 18'sd1 || s.h < 18'sd1)
                begin
                    s.ok = 1'b0;
                end
            end
        end
        st_out = s;
    end

endmodule

### sv/blit_rectangle_clipper_top.sv
// Blit rectangle clipper.
// Input channel: in_valid / in_stall with one blit request per item. The
// request is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with one result item per request:
// visible plus the clipped rectangle and source offset, all zero when the
// request is clipped away.
// Configuration: cfg_valid / cfg_ready write port, cfg_index selects one of
// the eight window edge registers. cfg_ready is always high; write only
// while no request is in flight.
// Timing: three register ranks (input, after the first clip pass, result);
// a request moves through them in that order. One request per cycle is
// sustained while out_stall is low; the depth is set by the two clip passes,
// each a chain of a few 18-bit adds and compares.
// The pipeline stalls rank by rank: a stalled result holds its register and
// earlier ranks keep filling, so in_stall rises only once all three ranks
// hold items.
// Reset empties the pipeline and loads the window registers with a
// 1024 x 768 window at the origin for both windows.
`include "blit_rectangle_clipper_top_macros.svh"

module blit_rectangle_clipper_top
    import brc_pkg::*;
#(
    parameter int SCREEN_DIM = 4096,
    parameter int BITMAP_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] dest_x,
    input  logic signed [15:0] dest_y,
    input  logic [12:0]        req_width,
    input  logic [12:0]        req_height,
    input  logic signed [13:0] src_x,
    input  logic signed [13:0] src_y,
    input  logic [12:0]        bitmap_width,
    input  logic [12:0]        bitmap_height,
    input  logic               use_alt_window,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               visible,
    output logic [11:0]        out_x,
    output logic [11:0]        out_y,
    output logic [12:0]        out_width,
    output logic [12:0]        out_height,
    output logic [11:0]        out_src_x,
    output logic [11:0]        out_src_y
);

    localparam coord_t EDGE_MAX = coord_t'(SCREEN_DIM - 1);
    localparam coord_t BMP_MAX  = coord_t'(BITMAP_DIM);

    logic [11:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;
    logic [11:0] alt_left_reg, alt_top_reg, alt_right_reg, alt_bottom_reg;

    stage_t      in_reg, in_next;
    stage_t      mid_reg, mid_next;
    logic        in_valid_reg, mid_valid_reg, out_valid_reg;
    clip_state_t pass1_st, pass2_st;

    logic        visible_reg, visible_next;
    logic [11:0] x_reg, x_next, y_reg, y_next, sx_reg, sx_next, sy_reg, sy_next;
    logic [12:0] w_reg, w_next, h_reg, h_next;

    logic        out_free, mid_free, in_free;
    logic [11:0] sel_l, sel_t, sel_r, sel_b;

    function automatic coord_t clamp_edge(input logic [11:0] e);
        coord_t v;
        v = {6'b0, e};
        if (v > EDGE_MAX)
        begin
            v = EDGE_MAX;
        end
        return v;
    endfunction

    function automatic coord_t clamp_bmp(input logic [12:0] b);
        coord_t v;
        v = {5'b0, b};
        if (v > BMP_MAX)
        begin
            v = BMP_MAX;
        end
        return v;
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= WIN_LEFT_RST;
            win_top_reg    <= WIN_TOP_RST;
            win_right_reg  <= WIN_RIGHT_RST;
            win_bottom_reg <= WIN_BOTTOM_RST;
            alt_left_reg   <= WIN_LEFT_RST;
            alt_top_reg    <= WIN_TOP_RST;
            alt_right_reg  <= WIN_RIGHT_RST;
            alt_bottom_reg <= WIN_BOTTOM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIN_LEFT:       win_left_reg   <= cfg_data;
                CFG_WIN_TOP:        win_top_reg    <= cfg_data;
                CFG_WIN_RIGHT:      win_right_reg  <= cfg_data;
                CFG_WIN_BOTTOM:     win_bottom_reg <= cfg_data;
                CFG_ALT_WIN_LEFT:   alt_left_reg   <= cfg_data;
                CFG_ALT_WIN_TOP:    alt_top_reg    <= cfg_data;
                CFG_ALT_WIN_RIGHT:  alt_right_reg  <= cfg_data;
                CFG_ALT_WIN_BOTTOM: alt_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow: each rank moves when the next one is empty or moving
    assign out_free = !out_valid_reg || !out_stall;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_free  = !in_valid_reg || mid_free;
    assign in_stall = !in_free;

    // input rank: window select, clamps and the initial far edges
    assign sel_l = use_alt_window ? alt_left_reg   : win_left_reg;
    assign sel_t = use_alt_window ? alt_top_reg    : win_top_reg;
    assign sel_r = use_alt_window ? alt_right_reg  : win_right_reg;
    assign sel_b = use_alt_window ? alt_bottom_reg : win_bottom_reg;

    always_comb
    begin
        in_next.win.cl   = clamp_edge(sel_l);
        in_next.win.ct   = clamp_edge(sel_t);
        in_next.win.cr   = clamp_edge(sel_r);
        in_next.win.cb   = clamp_edge(sel_b);
        in_next.bw       = clamp_bmp(bitmap_width);
        in_next.bh       = clamp_bmp(bitmap_height);
        in_next.st.x1    = {{2{dest_x[15]}}, dest_x};
        in_next.st.y1    = {{2{dest_y[15]}}, dest_y};
        in_next.st.w     = {5'b0, req_width};
        in_next.st.h     = {5'b0, req_height};
        in_next.st.x2    = in_next.st.x1 + in_next.st.w - 18'sd1;
        in_next.st.y2    = in_next.st.y1 + in_next.st.h - 18'sd1;
        in_next.st.sx    = {{4{src_x[13]}}, src_x};
        in_next.st.sy    = {{4{src_y[13]}}, src_y};
        in_next.st.ok    = 1'b1;
        in_next.st.again = 1'b1;
    end

    brc_clip_pass u_pass1 (
        .st_in  (in_reg.st),
        .win    (in_reg.win),
        .bw     (in_reg.bw),
        .bh     (in_reg.bh),
        .st_out (pass1_st)
    );

    always_comb
    begin
        mid_next    = in_reg;
        mid_next.st = pass1_st;
    end

    // second pass only runs when the first one moved the destination
    brc_clip_pass u_pass2 (
        .st_in  (mid_reg.st),
        .win    (mid_reg.win),
        .bw     (mid_reg.bw),
        .bh     (mid_reg.bh),
        .st_out (pass2_st)
    );

    always_comb
    begin
        visible_next = pass2_st.ok;
        x_next  = pass2_st.ok ? pass2_st.x1[11:0] : 12'd0;
        y_next  = pass2_st.ok ? pass2_st.y1[11:0] : 12'd0;
        w_next  = pass2_st.ok ? pass2_st.w[12:0]  : 13'd0;
        h_next  = pass2_st.ok ? pass2_st.h[12:0]  : 13'd0;
        sx_next = pass2_st.ok ? pass2_st.sx[11:0] : 12'd0;
        sy_next = pass2_st.ok ? pass2_st.sy[11:0] : 12'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= in_valid;
            end
            if (mid_free)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            in_reg <= in_next;
        end
        if (mid_free && in_valid_reg)
        begin
            mid_reg <= mid_next;
        end
        if (out_free && mid_valid_reg)
        begin
            visible_reg <= visible_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign visible    = visible_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_width  = w_reg;
    assign out_height = h_reg;
    assign out_src_x  = sx_reg;
    assign out_src_y  = sy_reg;

    `BRC_ASSERT_IMPL(a_hidden_zero, clk, rst_n, out_valid_reg && !visible_reg,
        x_reg == 12'd0 && y_reg == 12'd0 && w_reg == 13'd0 && h_reg == 13'd0 &&
        sx_reg == 12'd0 && sy_reg == 12'd0)
    `BRC_ASSERT_IMPL(a_visible_size, clk, rst_n, out_valid_reg && visible_reg,
        w_reg != 13'd0 && h_reg != 13'd0)
    `BRC_ASSERT_IMPL(a_pass1_inside, clk, rst_n, mid_valid_reg && mid_reg.st.ok,
        mid_reg.st.x1 >= mid_reg.win.cl && mid_reg.st.y1 >= mid_reg.win.ct &&
        mid_reg.st.sx >= 0 && mid_reg.st.sy >= 0)
    `BRC_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_reg && !mid_free,
        in_valid_reg)

endmodule
